// File: src/hsli_pkg.sv
// Package with shared constants, codes and types of the hinted table interpolator.
package hsli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int VAL_W       = 16;
    localparam int KIND_W      = 2;
    localparam int ENTRY_W     = 6;
    localparam int MAXI_W      = 6;
    localparam int SEG_W       = 6;
    localparam int DIV_CNT_W   = $clog2(FRAC_BITS);

    localparam logic [MAXI_W-1:0] MAX_INDEX_RESET = MAXI_W'(63);

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_LOOKUP = 2'd0;
    localparam t_kind KIND_WR_X   = 2'd1;
    localparam t_kind KIND_WR_Y   = 2'd2;

    typedef logic signed [IDX_W+1:0] t_sidx;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CLAMP  = 9'b000000010,
        S_YCLAMP = 9'b000000100,
        S_SEARCH = 9'b000001000,
        S_YRD    = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_MUL    = 9'b001000000,
        S_SUM    = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

endpackage

// File: src/hsli_in_if.sv
// Input channel: valid, ready and the fields of one input word.
interface hsli_in_if;
    import hsli_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [ENTRY_W-1:0]        entry_index;
    logic signed [VAL_W-1:0]   entry_value;
    logic signed [VAL_W-1:0]   x_in;

    modport source (output valid, kind, entry_index, entry_value, x_in, input ready);
    modport sink   (input valid, kind, entry_index, entry_value, x_in, output ready);
endinterface

// File: src/hsli_out_if.sv
// Output channel: valid, ready and the fields of one result word.
interface hsli_out_if;
    import hsli_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VAL_W-1:0]   y_out;
    logic [SEG_W-1:0]          segment;

    modport source (output valid, y_out, segment, input ready);
    modport sink   (input valid, y_out, segment, output ready);
endinterface

// File: src/hinted_search_linear_interp_top.sv
// Top level of the hinted binary search piecewise linear table interpolator.
//
// Input words arrive on i_in and results leave on o_out, both valid/ready.
// A word of kind 1 or 2 writes one x or y breakpoint in the cycle it is
// accepted and gives no result; kind 3 is dropped. A lookup word gives one
// result word with the interpolated y and the left segment index.
// The block works on one word at a time and takes the next word once the
// previous result sits in the output register, even while it is stalled.
// A lookup clamped at a table end goes through the clamp, y read and done
// states to the output register. An interior lookup runs P binary search
// probes, P from 1 to 65, one per cycle on the dual read x table RAM; a hint
// on the right segment is found by the first probe. It then reads y, runs
// the bit-serial fraction division, skipped when the fraction is zero or
// saturates, multiplies and sums. The user must write max_index through
// i_cfg_we/i_cfg_wdata only while the block is idle; the block does not enforce it.
// Reset clears the search hint to 0 and sets max_index to 63; the tables are
// not cleared and must be written before use.
// A stalled receiver holds the result in the output register; a second
// finished lookup then waits in its last step until the register frees up.
module hinted_search_linear_interp_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [hsli_pkg::MAXI_W-1:0] i_cfg_wdata,
    hsli_in_if.sink                   i_in,
    hsli_out_if.source                o_out
);
    import hsli_pkg::*;

    localparam int SUM_W  = VAL_W + 3;
    localparam int PROD_W = VAL_W + FRAC_BITS + 2;

    t_state                     r_state, n_state;
    logic [MAXI_W-1:0]          r_max_index, n_max_index;
    logic [IDX_W-1:0]           r_hint, n_hint;
    logic                       r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0]    r_out_y, n_out_y;
    logic [SEG_W-1:0]           r_out_seg, n_out_seg;

    logic signed [VAL_W-1:0]    r_x, n_x;
    logic [IDX_W-1:0]           r_top, n_top;
    logic [IDX_W-1:0]           r_idx, n_idx;
    t_sidx                      r_left, n_left;
    t_sidx                      r_right, n_right;
    logic [IDX_W-1:0]           r_step, n_step;
    logic                       r_final, n_final;
    logic [IDX_W-1:0]           r_seg, n_seg;
    logic                       r_div, n_div;
    logic [VAL_W-1:0]           r_rem, n_rem;
    logic [VAL_W-1:0]           r_den, n_den;
    logic [FRAC_BITS-1:0]       r_frac, n_frac;
    logic [DIV_CNT_W-1:0]       r_cnt, n_cnt;
    logic signed [VAL_W-1:0]    r_y0, n_y0;
    logic signed [VAL_W-1:0]    r_y1, n_y1;
    logic signed [PROD_W-1:0]   r_prod, n_prod;
    logic signed [VAL_W-1:0]    r_res_y, n_res_y;

    logic                       in_fire;
    logic [IDX_W-1:0]           cfg_top;
    logic [IDX_W-1:0]           top_m1;
    logic [IDX_W-1:0]           hint_c;
    logic [IDX_W-1:0]           x_raddr_a, x_raddr_b, y_raddr_a, y_raddr_b;
    logic [VAL_W-1:0]           x_rdata_a, x_rdata_b, y_rdata_a, y_rdata_b;
    logic signed [VAL_W-1:0]    xa, xb;
    logic                       lt0, lt1, found;
    t_sidx                      idx_s, s_sum, raw_idx;
    logic [IDX_W-1:0]           new_idx;
    logic signed [VAL_W:0]      dx, den;
    logic [VAL_W:0]             rem2, rem_diff;
    logic                       rem_ge;
    logic signed [VAL_W:0]      dy;
    logic signed [VAL_W+1:0]    q;
    logic signed [SUM_W-1:0]    y_sum;
    logic signed [VAL_W-1:0]    y_sat;

    assign in_fire     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.y_out = r_out_y;
    assign o_out.segment = r_out_seg;

    always_comb begin
        if (int'(r_max_index) > TABLE_DEPTH - 1) begin
            cfg_top = IDX_W'(TABLE_DEPTH - 1);
        end else begin
            cfg_top = IDX_W'(r_max_index);
        end
    end

    assign top_m1 = r_top - IDX_W'(1);
    assign hint_c = (r_hint > top_m1) ? top_m1 : r_hint;
    assign xa     = $signed(x_rdata_a);
    assign xb     = $signed(x_rdata_b);

    // One search probe: compare against both ends of the current segment.
    always_comb begin
        lt0   = r_x < xa;
        lt1   = r_x < xb;
        found = r_final || (!lt0 && lt1);
        idx_s = $signed({2'b00, r_idx});
        if (lt0) begin
            s_sum = idx_s + r_left - t_sidx'(1);
        end else begin
            s_sum = idx_s + r_right + t_sidx'(1);
        end
        raw_idx = (s_sum < 0) ? t_sidx'(0) : (s_sum >>> 1);
        if (raw_idx > $signed({2'b00, top_m1})) begin
            new_idx = top_m1;
        end else begin
            new_idx = raw_idx[IDX_W-1:0];
        end
    end

    assign dx = $signed({r_x[VAL_W-1], r_x}) - $signed({xa[VAL_W-1], xa});
    assign den = $signed({xb[VAL_W-1], xb}) - $signed({xa[VAL_W-1], xa});

    assign rem2     = {r_rem, 1'b0};
    assign rem_ge   = rem2 >= {1'b0, r_den};
    assign rem_diff = rem2 - {1'b0, r_den};

    assign dy = $signed({r_y1[VAL_W-1], r_y1}) - $signed({r_y0[VAL_W-1], r_y0});

    always_comb begin
        q     = r_prod[FRAC_BITS+VAL_W+1:FRAC_BITS];
        y_sum = $signed({{(SUM_W-VAL_W){r_y0[VAL_W-1]}}, r_y0})
              + $signed({{(SUM_W-VAL_W-2){q[VAL_W+1]}}, q});
        if (y_sum[SUM_W-1:VAL_W-1] == '0 || y_sum[SUM_W-1:VAL_W-1] == '1) begin
            y_sat = y_sum[VAL_W-1:0];
        end else if (y_sum[SUM_W-1]) begin
            y_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    always_comb begin
        x_raddr_a = '0;
        x_raddr_b = '0;
        y_raddr_a = '0;
        y_raddr_b = '0;
        unique case (r_state)
            S_IDLE: begin
                x_raddr_b = cfg_top;
            end
            S_CLAMP: begin
                x_raddr_a = hint_c;
                x_raddr_b = hint_c + IDX_W'(1);
                y_raddr_a = (r_x <= xa) ? '0 : r_top;
            end
            S_SEARCH: begin
                x_raddr_a = new_idx;
                x_raddr_b = new_idx + IDX_W'(1);
                y_raddr_a = r_idx;
                y_raddr_b = r_idx + IDX_W'(1);
            end
            default: begin
                x_raddr_a = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_max_index = i_cfg_we ? i_cfg_wdata : r_max_index;
        n_hint      = r_hint;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_y     = r_out_y;
        n_out_seg   = r_out_seg;
        n_x         = r_x;
        n_top       = r_top;
        n_idx       = r_idx;
        n_left      = r_left;
        n_right     = r_right;
        n_step      = r_step;
        n_final     = r_final;
        n_seg       = r_seg;
        n_div       = r_div;
        n_rem       = r_rem;
        n_den       = r_den;
        n_frac      = r_frac;
        n_cnt       = r_cnt;
        n_y0        = r_y0;
        n_y1        = r_y1;
        n_prod      = r_prod;
        n_res_y     = r_res_y;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && i_in.kind == KIND_LOOKUP) begin
                    n_x     = i_in.x_in;
                    n_top   = cfg_top;
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                if (r_x <= xa) begin
                    n_seg   = '0;
                    n_state = S_YCLAMP;
                end else if (r_x < xb) begin
                    n_idx   = hint_c;
                    n_left  = '0;
                    n_right = $signed({2'b00, r_top});
                    n_step  = '0;
                    n_final = 1'b0;
                    n_state = S_SEARCH;
                end else begin
                    n_seg   = r_top;
                    n_state = S_YCLAMP;
                end
            end
            S_YCLAMP: begin
                n_res_y = $signed(y_rdata_a);
                n_state = S_DONE;
            end
            S_SEARCH: begin
                if (found) begin
                    n_seg   = r_idx;
                    n_frac  = '0;
                    n_div   = 1'b0;
                    n_cnt   = DIV_CNT_W'(FRAC_BITS - 1);
                    n_rem   = dx[VAL_W-1:0];
                    n_den   = den[VAL_W-1:0];
                    if (den > 0 && dx > 0) begin
                        if (dx >= den) begin
                            n_frac = '1;
                        end else begin
                            n_div = 1'b1;
                        end
                    end
                    n_state = S_YRD;
                end else begin
                    if (lt0) begin
                        n_right = idx_s - t_sidx'(1);
                    end else begin
                        n_left = idx_s + t_sidx'(1);
                    end
                    n_idx = new_idx;
                    if (r_step == IDX_W'(TABLE_DEPTH - 1)) begin
                        n_final = 1'b1;
                    end else begin
                        n_step = r_step + IDX_W'(1);
                    end
                end
            end
            S_YRD: begin
                n_y0    = $signed(y_rdata_a);
                n_y1    = $signed(y_rdata_b);
                n_state = r_div ? S_DIV : S_MUL;
            end
            S_DIV: begin
                n_rem  = rem_ge ? rem_diff[VAL_W-1:0] : rem2[VAL_W-1:0];
                n_frac = {r_frac[FRAC_BITS-2:0], rem_ge};
                n_cnt  = r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = dy * $signed({1'b0, r_frac});
                n_state = S_SUM;
            end
            S_SUM: begin
                n_res_y = y_sat;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_y     = r_res_y;
                    n_out_seg   = SEG_W'(r_seg);
                    n_hint      = r_seg;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_index <= MAX_INDEX_RESET;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_max_index <= n_max_index;
            r_hint      <= n_hint;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_y   <= n_out_y;
        r_out_seg <= n_out_seg;
        r_x       <= n_x;
        r_top     <= n_top;
        r_idx     <= n_idx;
        r_left    <= n_left;
        r_right   <= n_right;
        r_step    <= n_step;
        r_final   <= n_final;
        r_seg     <= n_seg;
        r_div     <= n_div;
        r_rem     <= n_rem;
        r_den     <= n_den;
        r_frac    <= n_frac;
        r_cnt     <= n_cnt;
        r_y0      <= n_y0;
        r_y1      <= n_y1;
        r_prod    <= n_prod;
        r_res_y   <= n_res_y;
    end

    hsli_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_x_ram (
        .i_clk     (i_clk),
        .i_we      (in_fire && i_in.kind == KIND_WR_X),
        .i_waddr   (IDX_W'(i_in.entry_index)),
        .i_wdata   (i_in.entry_value),
        .i_raddr_a (x_raddr_a),
        .i_raddr_b (x_raddr_b),
        .o_rdata_a (x_rdata_a),
        .o_rdata_b (x_rdata_b)
    );

    hsli_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_y_ram (
        .i_clk     (i_clk),
        .i_we      (in_fire && i_in.kind == KIND_WR_Y),
        .i_waddr   (IDX_W'(i_in.entry_index)),
        .i_wdata   (i_in.entry_value),
        .i_raddr_a (y_raddr_a),
        .i_raddr_b (y_raddr_b),
        .o_rdata_a (y_rdata_a),
        .o_rdata_b (y_rdata_b)
    );
endmodule

// File: src/hsli_ram.sv
// Generic RAM with one write port and two registered read ports.
module hsli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

// File: bench/tb_top.sv
// Self-checking testbench that drives table writes and lookups and checks each interpolated result.
module tb_top;
    import hsli_pkg::*;

    localparam int    HALF_PERIOD   = 10;
    localparam int    RESET_CYCLES  = 5;
    localparam int    SETTLE_CYCLES = 100;
    localparam int    LIMIT_CYCLES  = 1_000_000;
    localparam int    MAX_GAP       = 8;
    localparam int    MAX_REPORTS   = 100;
    localparam int    VAL_MIN       = -32768;
    localparam int    VAL_MAX       = 32767;
    localparam t_kind KIND_NONE     = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] y_out;
        logic [SEG_W-1:0]        segment;
    } t_lookup_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [MAXI_W-1:0] i_cfg_wdata;

    hsli_in_if  in_if ();
    hsli_out_if out_if ();

    hinted_search_linear_interp_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    logic signed [VAL_W-1:0] x_bp [TABLE_DEPTH];
    logic signed [VAL_W-1:0] y_bp [TABLE_DEPTH];
    int                      seg_hint = 0;
    logic [MAXI_W-1:0]       top_index = MAX_INDEX_RESET;
    t_lookup_result          pending_results [$];
    int                      error_count = 0;
    int                      cycle_count;
    bit                      steady = 1'b0;
    int                      last_x = 0;

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int find_segment_for(int x, int top);
        int idx;
        int left;
        int right;
        int s;
        int n;
        idx = clamp_int(seg_hint, 0, top - 1);
        left = 0;
        right = top;
        for (n = 0; n < TABLE_DEPTH; n++) begin
            idx = clamp_int(idx, 0, top - 1);
            if (x < int'(x_bp[idx])) begin
                right = idx - 1;
                s = idx + left - 1;
                idx = (s < 0) ? 0 : s / 2;
            end else if (x < int'(x_bp[idx + 1])) begin
                return idx;
            end else begin
                left = idx + 1;
                s = idx + right + 1;
                idx = (s < 0) ? 0 : s / 2;
            end
        end
        return clamp_int(idx, 0, top - 1);
    endfunction

    function automatic int interpolate_at(int x, int i);
        longint dx;
        longint den;
        longint frac;
        longint fmax;
        longint p;
        longint yv;
        dx = longint'(x) - longint'(x_bp[i]);
        den = longint'(x_bp[i + 1]) - longint'(x_bp[i]);
        fmax = (longint'(1) << FRAC_BITS) - 1;
        frac = 0;
        if (den > 0 && dx > 0) begin
            frac = (dx << FRAC_BITS) / den;
            if (frac > fmax) frac = fmax;
        end
        p = (longint'(y_bp[i + 1]) - longint'(y_bp[i])) * frac;
        yv = longint'(y_bp[i]) + (p >>> FRAC_BITS);
        if (yv > VAL_MAX) yv = VAL_MAX;
        if (yv < VAL_MIN) yv = VAL_MIN;
        return int'(yv);
    endfunction

    function automatic t_lookup_result predict_lookup(int x);
        t_lookup_result r;
        int top;
        int seg;
        int yv;
        top = int'(top_index);
        if (x <= int'(x_bp[0])) begin
            seg = 0;
            yv = int'(y_bp[0]);
        end else if (x < int'(x_bp[top])) begin
            seg = find_segment_for(x, top);
            yv = interpolate_at(x, seg);
        end else begin
            seg = top;
            yv = int'(y_bp[top]);
        end
        seg_hint = seg;
        r.y_out = VAL_W'(yv);
        r.segment = SEG_W'(seg);
        return r;
    endfunction

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        return VAL_W'($urandom);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        end
    endtask

    task automatic send_word(t_kind kind, logic [ENTRY_W-1:0] idx,
                             logic signed [VAL_W-1:0] val, logic signed [VAL_W-1:0] x);
        int gap;
        gap = draw_gap();
        repeat (gap) @(negedge i_clk) in_if.valid <= 1'b0;
        @(negedge i_clk);
        in_if.valid       <= 1'b1;
        in_if.kind        <= kind;
        in_if.entry_index <= idx;
        in_if.entry_value <= val;
        in_if.x_in        <= x;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        case (kind)
            KIND_WR_X:   x_bp[idx] = val;
            KIND_WR_Y:   y_bp[idx] = val;
            KIND_LOOKUP: pending_results.push_back(predict_lookup(int'(x)));
            default: ;
        endcase
    endtask

    task automatic query(int x);
        last_x = x;
        send_word(KIND_LOOKUP, ENTRY_W'($urandom), rand_value(), VAL_W'(x));
    endtask

    task automatic write_x(int i, int v);
        send_word(KIND_WR_X, ENTRY_W'(i), VAL_W'(v), rand_value());
    endtask

    task automatic write_y(int i, int v);
        send_word(KIND_WR_Y, ENTRY_W'(i), VAL_W'(v), rand_value());
    endtask

    task automatic quiesce();
        @(negedge i_clk) in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_index(logic [MAXI_W-1:0] m);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        top_index = m;
    endtask

    task automatic load_initial_table();
        int i;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            write_x(i, (i == TABLE_DEPTH - 1) ? VAL_MAX : VAL_MIN + i * 1040);
            case (i)
                0:       write_y(i, VAL_MIN);
                1:       write_y(i, VAL_MAX);
                2:       write_y(i, VAL_MIN);
                default: write_y(i, int'(rand_value()));
            endcase
        end
    endtask

    task automatic load_ramp_table(int top);
        int steps [TABLE_DEPTH];
        int step_max;
        int total;
        int xv;
        int i;
        case ($urandom_range(0, 3))
            0:       step_max = 1;
            1:       step_max = 16;
            2:       step_max = 512;
            default: step_max = 65535;
        endcase
        if (top > 0 && step_max * top > 65535) step_max = 65535 / top;
        total = 0;
        for (i = 1; i <= top; i++) begin
            steps[i] = $urandom_range(1, step_max);
            total += steps[i];
        end
        xv = VAL_MIN + int'($urandom_range(0, 65535 - total));
        for (i = 0; i <= top; i++) begin
            if (i > 0) xv += steps[i];
            write_x(i, xv);
            write_y(i, int'(rand_value()));
        end
    endtask

    task automatic test_table_ends();
        query(VAL_MIN);
        query(VAL_MAX);
        query(VAL_MAX - 1);
        query(int'(x_bp[0]) + 1);
        query(int'(x_bp[1]) + 700);
    endtask

    task automatic test_interior_points();
        query(int'(x_bp[5]));
        query(int'(x_bp[5]) + 1);
        query(int'(x_bp[6]) - 1);
        query(int'(x_bp[40]) + 520);
        query(int'(x_bp[40]) + 600);
    endtask

    task automatic test_ignored_kind();
        send_word(KIND_NONE, '1, '1, '1);
        query(-1);
    endtask

    task automatic test_irregular_table();
        int saved;
        saved = int'(x_bp[30]);
        write_x(30, VAL_MIN);
        query(int'(x_bp[29]) + 10);
        query(int'(x_bp[31]) + 5);
        write_x(30, saved);
        saved = int'(x_bp[20]);
        write_x(20, int'(x_bp[21]));
        query(int'(x_bp[20]));
        query(int'(x_bp[19]) + 3);
        write_x(20, saved);
    endtask

    task automatic test_index_extremes();
        quiesce();
        write_max_index(MAXI_W'(0));
        query(VAL_MIN);
        query(0);
        query(VAL_MAX);
        quiesce();
        write_max_index(MAXI_W'(1));
        query(int'(x_bp[0]) + 100);
        query(VAL_MAX);
        quiesce();
        write_max_index(MAXI_W'(63));
    endtask

    task automatic run_random_phase(logic [MAXI_W-1:0] top, int n_words);
        int sent;
        int pick;
        int lo;
        int hi;
        int k;
        quiesce();
        write_max_index(top);
        load_ramp_table(int'(top));
        sent = 2 * (int'(top) + 1);
        while (sent < n_words) begin
            if (sent % 50 == 0) steady = ($urandom_range(0, 3) == 0);
            lo = int'(x_bp[0]);
            hi = int'(x_bp[top]);
            if (lo > hi) begin
                k = lo;
                lo = hi;
                hi = k;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                query(lo + int'($urandom_range(0, hi - lo)));
            end else if (pick < 65) begin
                query(clamp_int(last_x + int'($urandom_range(0, 64)) - 32, VAL_MIN, VAL_MAX));
            end else if (pick < 73) begin
                query(clamp_int(int'(x_bp[$urandom_range(0, top)]) + int'($urandom_range(0, 2)) - 1,
                                VAL_MIN, VAL_MAX));
            end else if (pick < 80) begin
                query(int'(rand_value()));
            end else if (pick < 84) begin
                query(($urandom_range(0, 1) == 1) ? VAL_MAX : VAL_MIN);
            end else if (pick < 90) begin
                write_y($urandom_range(0, top), int'(rand_value()));
            end else if (pick < 94) begin
                write_x($urandom_range(0, top), int'(rand_value()));
            end else if (pick < 97) begin
                send_word(KIND_NONE, ENTRY_W'($urandom), rand_value(), rand_value());
                sent--;
            end else if (pick < 99) begin
                write_x($urandom_range(0, TABLE_DEPTH - 1), int'(rand_value()));
            end else begin
                write_y($urandom_range(0, TABLE_DEPTH - 1), int'(rand_value()));
            end
            sent++;
        end
        steady = 1'b0;
    endtask

    task automatic test_random_phases();
        run_random_phase(MAXI_W'(63), 180);
        run_random_phase(MAXI_W'(1), 80);
        run_random_phase(MAXI_W'(0), 30);
        run_random_phase(MAXI_W'(32), 130);
        run_random_phase(MAXI_W'($urandom_range(2, 62)), 130);
        run_random_phase(MAXI_W'($urandom_range(2, 62)), 130);
        run_random_phase(MAXI_W'(63), 200);
    endtask

    initial begin : result_drain
        int stall;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_gap();
            repeat (stall) @(negedge i_clk) out_if.ready <= 1'b0;
            @(negedge i_clk) out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_lookup_result want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, segment", int'(out_if.segment), -1);
            end else begin
                want = pending_results.pop_front();
                if (out_if.y_out !== want.y_out) begin
                    report_mismatch("y_out", int'(out_if.y_out), int'(want.y_out));
                end
                if (out_if.segment !== want.segment) begin
                    report_mismatch("segment", int'(out_if.segment), int'(want.segment));
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_if.valid       = 1'b0;
        in_if.kind        = KIND_LOOKUP;
        in_if.entry_index = '0;
        in_if.entry_value = '0;
        in_if.x_in        = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        write_max_index(MAX_INDEX_RESET);
        load_initial_table();
        test_table_ends();
        test_interior_points();
        test_ignored_kind();
        test_irregular_table();
        test_index_extremes();
        test_random_phases();
        quiesce();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
